### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation builds get concurrent
// assertions that report through $error; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

### hw/rtl/mtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

   // Frame geometry limits and derived widths.
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PIX_W       = 8;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
   localparam int WORD_W      = 2 * PIX_W;

   // Register port.
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int TRIM_W      = 3;
   localparam int MAX_TRIM    = 4;

   // Filter arithmetic: the mean of up to nine pixels is a multiply by a
   // reciprocal scaled by two to the RECIP_SHIFT.
   localparam int WIN_SIZE    = 9;
   localparam int SUM_W       = 12;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int FILT_STAGES = 7;

   // Result queue.
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int RES_W       = FIFO_AW + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_TRIM_MODE    = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_PUSH  = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_type;
   typedef logic [MAX_TRIM:0][PIX_W:0]     part_type;

   // Control carried from the accept stage to the line store stage.
   typedef struct packed {
      logic             valid;
      logic             drain;
      logic             first;
      logic             row0;
      logic             emit1;
      logic             emit2;
      logic             last;
      logic [COL_W-1:0] addr;
   } stage_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             row_end;
      logic             frame_end;
   } result_type;

   // One layer of an odd-even transposition sort: compare and swap the
   // neighbor pairs that start at even (odd = 0) or odd positions.
   function automatic window_type oet_layer(input window_type v, input logic odd);
      window_type r;
      int         lo;
      r = v;
      for (int i = 0; i < (WIN_SIZE - 1) / 2; i++) begin
         lo = 2 * i + (odd ? 1 : 0);
         if (v[lo] > v[lo + 1]) begin
            r[lo]     = v[lo + 1];
            r[lo + 1] = v[lo];
         end
      end
      return r;
   endfunction

   // Reciprocal of the count of averaged values (1, 3, 5, 7 or 9), rounded
   // up. Exact for every sum of up to nine 8-bit values.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [TRIM_W-1:0] k);
      logic [RECIP_W-1:0] m;
      case (k)
         3'd0:    m = RECIP_W'(65536);
         3'd1:    m = RECIP_W'(21846);
         3'd2:    m = RECIP_W'(13108);
         3'd3:    m = RECIP_W'(9363);
         default: m = RECIP_W'(7282);
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/mtm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel input channel.
interface mtm_req_if import mtm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, func, pixel_in, input ready);
   modport sink   (input valid, func, pixel_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/mtm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Filtered pixel output channel.
interface mtm_rsp_if import mtm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             row_end;
   logic             frame_end;

   modport source (output valid, pixel_out, row_end, frame_end, input ready);
   modport sink   (input valid, pixel_out, row_end, frame_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/median_trimmed_mean_3x3_filter.sv
// 3x3 median / trimmed-mean filter for 8-bit grey frames.
//
// req_chan takes one transaction per pixel in raster order (func push) and,
// once the frame is complete, one drain transaction per pixel of the last
// row. rsp_chan returns the filtered pixels in raster order with row_end and
// frame_end flags. Results lag the input by one row and one column; borders
// replicate the nearest pixel. Register writes on the csr port (width,
// height, trim mode) are made while the block is idle; width or height
// writes restart the frame.
//
// Throughput is one transaction per clock while the result queue has room.
// The last push of each row after the first produces two results, and the
// input pauses after it so the single sort unit can take the second window.
// Results pass the line store stage and the filter pipeline to the queue.
// The line store is a 1024 x 16 RAM holding the two previous rows
// per column, one read and one write per cycle, with write-to-read
// forwarding. Results wait in a 16-entry queue; the input stalls when the
// queue plus results still in the pipeline could fill it, so a stalled
// receiver loses nothing. Reset clears counters and sets width and height
// to 1024 and trim mode to median; the line store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module median_trimmed_mean_3x3_filter import mtm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mtm_req_if.sink               req_chan,
   mtm_rsp_if.source             rsp_chan
);

   // Configuration.
   logic [COL_W-1:0]  w_last_ff, w_last_in;
   logic [ROW_W-1:0]  h_ff, h_in;
   logic [TRIM_W-1:0] k_ff, k_in;
   logic              geom_write;

   // Frame counters.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] drain_ff, drain_in;

   // Accept stage.
   logic      req_fire, frame_done, col_last, drain_last, drain_ok, push_ok;
   stage_type a_stage;
   logic [1:0] n_new;

   // Line store stage.
   stage_type         b_ff;
   logic [PIX_W-1:0]  b_pix_ff;
   logic              b_fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0] b_fwd_data_ff;
   logic [WORD_W-1:0] ram_rd_data, rd_word, wr_data;
   logic              wr_en;
   logic [PIX_W-1:0]  top, mid;
   logic [PIX_W-1:0]  new_col [3];
   logic [PIX_W-1:0]  c0_col [3];
   logic [WORD_W-1:0] col0_ff, col0_in;
   window_type        win_ff, win_in;
   logic              tail_ff, tail_in;
   logic              issue, issue_re, issue_fe;

   // Filter pipeline.
   logic [FILT_STAGES-1:0] pv_ff, pre_ff, pfe_ff;
   window_type             p0_win_ff, p1_win_ff, p2_win_ff, p3_win_ff;
   part_type               p4_part_ff, part_in;
   logic [SUM_W-1:0]       p5_sum_ff;
   logic [PROD_W-1:0]      p6_prod_ff, prod;

   // Result queue and credits.
   result_type       fifo_ff [FIFO_DEPTH];
   result_type       fifo_wr;
   logic [RES_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RES_W-1:0] reserved_ff, reserved_in;
   logic             rsp_fire;

   // Register writes: clamp geometry and trim mode as they are stored.
   always_comb begin
      w_last_in  = w_last_ff;
      h_in       = h_ff;
      k_in       = k_ff;
      geom_write = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               geom_write = 1'b1;
               if (csr_wdata == '0) begin
                  w_last_in = '0;
               end else if (csr_wdata > CSR_DATA_W'(MAX_WIDTH)) begin
                  w_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = COL_W'(csr_wdata - 1'b1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               geom_write = 1'b1;
               if (csr_wdata == '0) begin
                  h_in = ROW_W'(1);
               end else if (csr_wdata > CSR_DATA_W'(MAX_HEIGHT)) begin
                  h_in = ROW_W'(MAX_HEIGHT);
               end else begin
                  h_in = ROW_W'(csr_wdata);
               end
            end
            CSR_TRIM_MODE: begin
               if (csr_wdata[TRIM_W-1:0] > TRIM_W'(MAX_TRIM)) begin
                  k_in = TRIM_W'(MAX_TRIM);
               end else begin
                  k_in = csr_wdata[TRIM_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Decode the accepted transaction against the frame position.
   always_comb begin
      req_fire   = req_chan.valid && req_chan.ready;
      frame_done = row_ff >= h_ff;
      col_last   = col_ff == w_last_ff;
      drain_last = drain_ff == w_last_ff;
      drain_ok   = req_fire && (req_chan.func == FUNC_DRAIN) && frame_done;
      push_ok    = req_fire && (req_chan.func == FUNC_PUSH) && !frame_done;
      a_stage       = '0;
      a_stage.valid = drain_ok || push_ok;
      a_stage.drain = drain_ok;
      if (drain_ok) begin
         a_stage.first = drain_ff == '0;
         a_stage.last  = drain_last;
         a_stage.addr  = drain_last ? w_last_ff : COL_W'(drain_ff + 1'b1);
      end else begin
         a_stage.first = col_ff == '0;
         a_stage.row0  = row_ff == '0;
         a_stage.emit1 = (row_ff != '0) && (col_ff != '0);
         a_stage.emit2 = (row_ff != '0) && col_last;
         a_stage.addr  = col_ff;
      end
      if (push_ok) begin
         n_new = 2'(a_stage.emit1) + 2'(a_stage.emit2);
      end else begin
         n_new = {1'b0, drain_ok};
      end
   end

   // Advance the column, row and drain counters.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (geom_write) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
      end else if (drain_ok) begin
         if (drain_last) begin
            col_in   = '0;
            row_in   = '0;
            drain_in = '0;
         end else begin
            drain_in = COL_W'(drain_ff + 1'b1);
         end
      end else if (push_ok) begin
         if (col_last) begin
            col_in = '0;
            row_in = ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
   end

   // Line store: each word holds {row two above, row above} of one column.
   mtm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_ff.addr),
      .wr_data (wr_data),
      .rd_addr (a_stage.addr),
      .rd_data (ram_rd_data)
   );

   // Read-modify-write of the line store and the window update.
   always_comb begin
      rd_word = b_fwd_hit_ff ? b_fwd_data_ff : ram_rd_data;
      top     = b_ff.row0 ? b_pix_ff : rd_word[WORD_W-1:PIX_W];
      mid     = b_ff.row0 ? b_pix_ff : rd_word[PIX_W-1:0];
      wr_data = {mid, b_pix_ff};
      wr_en   = b_ff.valid && !b_ff.drain;
      fwd_hit_in = wr_en && (b_ff.addr == a_stage.addr);
      col0_in = (wr_en && b_ff.first) ? wr_data : col0_ff;
      tail_in = wr_en && b_ff.emit2;

      // The bottom row repeats the row above while draining.
      if (b_ff.drain) begin
         new_col[0] = rd_word[WORD_W-1:PIX_W];
         new_col[1] = rd_word[PIX_W-1:0];
         new_col[2] = rd_word[PIX_W-1:0];
      end else begin
         new_col[0] = top;
         new_col[1] = mid;
         new_col[2] = b_pix_ff;
      end
      c0_col[0] = col0_ff[WORD_W-1:PIX_W];
      c0_col[1] = col0_ff[PIX_W-1:0];
      c0_col[2] = col0_ff[PIX_W-1:0];

      win_in   = win_ff;
      issue    = 1'b0;
      issue_re = 1'b0;
      issue_fe = 1'b0;
      if (b_ff.valid) begin
         for (int r = 0; r < 3; r++) begin
            if (b_ff.first && b_ff.drain) begin
               win_in[r * 3]     = c0_col[r];
               win_in[r * 3 + 1] = c0_col[r];
               win_in[r * 3 + 2] = new_col[r];
            end else if (b_ff.first) begin
               win_in[r * 3]     = new_col[r];
               win_in[r * 3 + 1] = new_col[r];
               win_in[r * 3 + 2] = new_col[r];
            end else begin
               win_in[r * 3]     = win_ff[r * 3 + 1];
               win_in[r * 3 + 1] = win_ff[r * 3 + 2];
               win_in[r * 3 + 2] = new_col[r];
            end
         end
         issue    = b_ff.drain ? 1'b1 : b_ff.emit1;
         issue_re = b_ff.drain && b_ff.last;
         issue_fe = b_ff.drain && b_ff.last;
      end else if (tail_ff) begin
         // Right border of a row: replicate the last column once more.
         for (int r = 0; r < 3; r++) begin
            win_in[r * 3]     = win_ff[r * 3 + 1];
            win_in[r * 3 + 1] = win_ff[r * 3 + 2];
         end
         issue    = 1'b1;
         issue_re = 1'b1;
      end
   end

   // Middle values of the sorted window, masked by the trim mode.
   always_comb begin
      part_in[0] = {1'b0, p3_win_ff[MAX_TRIM]};
      for (int j = 1; j <= MAX_TRIM; j++) begin
         if (k_ff >= TRIM_W'(j)) begin
            part_in[j] = {1'b0, p3_win_ff[MAX_TRIM - j]} + {1'b0, p3_win_ff[MAX_TRIM + j]};
         end else begin
            part_in[j] = '0;
         end
      end
   end

   // Sum divided by 1, 3, 5, 7 or 9 through the scaled reciprocal.
   assign prod = p5_sum_ff * recip_of(k_ff);

   // Handshakes and result queue.
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = !tail_in && (reserved_ff <= RES_W'(FIFO_DEPTH - 2));
   assign reserved_in    = RES_W'(reserved_ff + RES_W'(n_new) - RES_W'(rsp_fire));

   assign fifo_wr.pixel_out = p6_prod_ff[RECIP_SHIFT +: PIX_W];
   assign fifo_wr.row_end   = pre_ff[FILT_STAGES-1];
   assign fifo_wr.frame_end = pfe_ff[FILT_STAGES-1];

   assign rsp_chan.valid     = wr_ptr_ff != rd_ptr_ff;
   assign rsp_chan.pixel_out = fifo_ff[rd_ptr_ff[FIFO_AW-1:0]].pixel_out;
   assign rsp_chan.row_end   = fifo_ff[rd_ptr_ff[FIFO_AW-1:0]].row_end;
   assign rsp_chan.frame_end = fifo_ff[rd_ptr_ff[FIFO_AW-1:0]].frame_end;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= COL_W'(MAX_WIDTH - 1);
         h_ff        <= ROW_W'(MAX_HEIGHT);
         k_ff        <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         b_ff        <= '0;
         tail_ff     <= 1'b0;
         pv_ff       <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         reserved_ff <= '0;
      end else begin
         w_last_ff   <= w_last_in;
         h_ff        <= h_in;
         k_ff        <= k_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         b_ff        <= a_stage;
         tail_ff     <= tail_in;
         pv_ff       <= {pv_ff[FILT_STAGES-2:0], issue};
         reserved_ff <= reserved_in;
         if (pv_ff[FILT_STAGES-1]) begin
            wr_ptr_ff <= RES_W'(wr_ptr_ff + 1'b1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= RES_W'(rd_ptr_ff + 1'b1);
         end
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      b_pix_ff      <= req_chan.pixel_in;
      b_fwd_hit_ff  <= fwd_hit_in;
      b_fwd_data_ff <= wr_data;
      col0_ff       <= col0_in;
      win_ff        <= win_in;
      pre_ff        <= {pre_ff[FILT_STAGES-2:0], issue_re};
      pfe_ff        <= {pfe_ff[FILT_STAGES-2:0], issue_fe};
      // Nine layers of transposition sort, three per stage.
      p0_win_ff     <= win_in;
      p1_win_ff     <= oet_layer(oet_layer(oet_layer(p0_win_ff, 1'b0), 1'b1), 1'b0);
      p2_win_ff     <= oet_layer(oet_layer(oet_layer(p1_win_ff, 1'b1), 1'b0), 1'b1);
      p3_win_ff     <= oet_layer(oet_layer(oet_layer(p2_win_ff, 1'b0), 1'b1), 1'b0);
      p4_part_ff    <= part_in;
      p5_sum_ff     <= SUM_W'(p4_part_ff[0]) + SUM_W'(p4_part_ff[1]) + SUM_W'(p4_part_ff[2])
                     + SUM_W'(p4_part_ff[3]) + SUM_W'(p4_part_ff[4]);
      p6_prod_ff    <= prod;
      if (pv_ff[FILT_STAGES-1]) begin
         fifo_ff[wr_ptr_ff[FIFO_AW-1:0]] <= fifo_wr;
      end
   end

   // Checks.
   `ASSERT_CLK(a_credit_bound, clock, reset, reserved_ff <= RES_W'(FIFO_DEPTH), "credit count exceeds queue depth")
   `ASSERT_CLK(a_queue_within_credit, clock, reset, RES_W'(wr_ptr_ff - rd_ptr_ff) <= reserved_ff, "queue holds more results than were reserved")
   `ASSERT_CLK(a_single_issue, clock, reset, !(tail_ff && b_ff.valid), "row end window collides with a new transaction")
   `ASSERT_CLK(a_tail_after_pause, clock, reset, tail_ff |-> !$past(req_fire), "transaction accepted during the row end pause")
   `ASSERT_CLK(a_drain_in_row, clock, reset, drain_ff <= w_last_ff, "drain position beyond the row")

endmodule

`default_nettype wire

### hw/rtl/mtm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write and one read per cycle, registered read.
// A read of the address being written returns the old contents.
module mtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### sim/median_trimmed_mean_3x3_filter_tb.sv
`timescale 1ns / 1ps

module median_trimmed_mean_3x3_filter_tb;
   import mtm_pkg::*;

   // Register index that no register answers to.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // Cycles without any transaction before the run is declared hung.
   localparam int unsigned QUIET_LIMIT = 4000;
   // Cycles the block may still be busy after its last result.
   localparam int unsigned SETTLE_CYCLES = 16;
   // Length of the forced receiver hold-off.
   localparam int unsigned SINK_HOLD_CYCLES = 250;
   localparam int PLAN_ROWS = 23;
   // Input transactions the random frames stop after.
   localparam int unsigned RANDOM_ITEMS = 680;
   // Pushes into the partial frame whose geometry is written above the limit.
   localparam int unsigned WIDE_PUSHES = 40;

   // One row of the directed stimulus: a register write or an input transaction.
   // Rows marked fixed carry their result in the row itself.
   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  fn;
      logic [PIX_W-1:0]      pix;
      logic                  fixed;
      logic                  has_out;
      logic [PIX_W-1:0]      out_pix;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mtm_req_if req_bus ();
   mtm_rsp_if rsp_bus ();

   median_trimmed_mean_3x3_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus)
   );

   always #1 clock = ~clock;

   // Filter state as the block should hold it.
   logic [PIX_W-1:0]      line_mem [0:2*MAX_WIDTH-1];
   window_type            win_q;
   int unsigned           col_n;
   int unsigned           row_n;
   int unsigned           drain_n;
   logic [CSR_DATA_W-1:0] width_reg = 11'd1024;
   logic [CSR_DATA_W-1:0] height_reg = 11'd1024;
   logic [TRIM_W-1:0]     trim_reg = '0;

   // Results of the last input transaction, and the filtered pixels still due.
   result_type            step_out [2];
   int unsigned           step_n;
   bit                    step_took;
   result_type            due [$];

   int unsigned           items_taken;
   int unsigned           fail_count;
   int unsigned           quiet_cycles;
   int unsigned           sink_hold_asks;
   int unsigned           sink_holds_done;
   int unsigned           source_style;
   plan_row_type          plan [PLAN_ROWS];

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                             input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // Sorts the nine window values and returns the median or the truncated mean
   // of the middle 2k+1 of them.
   function automatic logic [PIX_W-1:0] rank_filter(input window_type w,
                                                    input logic [TRIM_W-1:0] trim);
      logic [PIX_W-1:0] s [9];
      logic [PIX_W-1:0] t;
      int               j;
      int unsigned      k;
      int unsigned      sum;
      for (int i = 0; i < 9; i++) s[i] = w[i];
      for (int a = 1; a < 9; a++) begin
         t = s[a];
         j = a - 1;
         while (j >= 0 && s[j] > t) begin
            s[j + 1] = s[j];
            j--;
         end
         s[j + 1] = t;
      end
      k = (trim > MAX_TRIM) ? MAX_TRIM : trim;
      if (k == 0) return s[4];
      sum = 0;
      for (int unsigned i = 4 - k; i <= 4 + k; i++) sum += s[i];
      return PIX_W'(sum / (2 * k + 1));
   endfunction

   // Moves the window one column to the left and loads the new right column.
   function automatic void shift_column(input logic [PIX_W-1:0] top,
                                        input logic [PIX_W-1:0] mid,
                                        input logic [PIX_W-1:0] bot);
      logic [PIX_W-1:0] col [3];
      col[0] = top;
      col[1] = mid;
      col[2] = bot;
      for (int r = 0; r < 3; r++) begin
         win_q[r*3]     = win_q[r*3 + 1];
         win_q[r*3 + 1] = win_q[r*3 + 2];
         win_q[r*3 + 2] = col[r];
      end
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = val;
            col_n = 0;
            row_n = 0;
            drain_n = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = val;
            col_n = 0;
            row_n = 0;
            drain_n = 0;
         end
         CSR_TRIM_MODE: begin
            trim_reg = val[TRIM_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Advances the filter state by one input transaction and leaves the
   // filtered pixels it produces in step_out.
   task automatic filter_step(input logic fn, input logic [PIX_W-1:0] pix);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      d;
      int unsigned      lo;
      int unsigned      hi;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      window_type       border_win;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      step_n = 0;
      step_took = 1'b0;
      if (fn == FUNC_DRAIN) begin
         // The last row is rebuilt from the line store, its lower row replicated.
         if (row_n >= h && drain_n < w) begin
            step_took = 1'b1;
            d = drain_n;
            lo = (d == 0) ? 0 : d - 1;
            hi = (d + 1 >= w) ? w - 1 : d + 1;
            border_win[0] = line_mem[MAX_WIDTH + lo];
            border_win[1] = line_mem[MAX_WIDTH + d];
            border_win[2] = line_mem[MAX_WIDTH + hi];
            border_win[3] = line_mem[lo];
            border_win[4] = line_mem[d];
            border_win[5] = line_mem[hi];
            border_win[6] = border_win[3];
            border_win[7] = border_win[4];
            border_win[8] = border_win[5];
            step_out[0] = '{pixel_out: rank_filter(border_win, trim_reg),
                            row_end: (d == w - 1), frame_end: (d == w - 1)};
            step_n = 1;
            drain_n = d + 1;
            if (drain_n >= w) begin
               col_n = 0;
               row_n = 0;
               drain_n = 0;
            end
         end
      end else if (row_n < h && col_n < w) begin
         step_took = 1'b1;
         x = col_n;
         if (row_n == 0) begin
            top = pix;
            mid = pix;
         end else begin
            top = line_mem[MAX_WIDTH + x];
            mid = line_mem[x];
         end
         line_mem[MAX_WIDTH + x] = mid;
         line_mem[x] = pix;
         // The first column of a row fills the whole window by replication.
         if (x == 0) begin
            repeat (3) shift_column(top, mid, pix);
         end else begin
            shift_column(top, mid, pix);
         end
         if (row_n >= 1) begin
            if (x >= 1) begin
               step_out[step_n] = '{pixel_out: rank_filter(win_q, trim_reg),
                                    row_end: 1'b0, frame_end: 1'b0};
               step_n++;
            end
            // The right border repeats the last column.
            if (x == w - 1) begin
               shift_column(win_q[2], win_q[5], win_q[8]);
               step_out[step_n] = '{pixel_out: rank_filter(win_q, trim_reg),
                                    row_end: 1'b1, frame_end: 1'b0};
               step_n++;
            end
         end
         col_n = x + 1;
         if (col_n >= w) begin
            col_n = 0;
            row_n++;
         end
      end
   endtask

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      return '{is_csr: 1'b1, reg_idx: idx, reg_val: val, default: '0};
   endfunction

   function automatic plan_row_type in_row(input logic fn, input logic [PIX_W-1:0] pix);
      return '{fn: fn, pix: pix, default: '0};
   endfunction

   // A transaction whose result is known by inspection. On a one pixel frame
   // the single result closes both its row and the frame.
   function automatic plan_row_type fixed_row(input logic fn, input logic [PIX_W-1:0] pix,
                                              input logic has_out,
                                              input logic [PIX_W-1:0] out_pix);
      return '{fn: fn, pix: pix, fixed: 1'b1, has_out: has_out, out_pix: out_pix,
               default: '0};
   endfunction

   // Gap length: most gaps are short, a few are long, style 0 never idles.
   function automatic int unsigned pick_gap(input int unsigned style);
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      case (style)
         0:       return 0;
         1:       return ($urandom_range(0, 7) == 0) ? n : 0;
         default: return ($urandom_range(0, 1) == 0) ? n : 0;
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 15) return 11'd1;
      if (r < 45) return CSR_DATA_W'($urandom_range(2, 4));
      if (r < 90) return CSR_DATA_W'($urandom_range(5, 16));
      return CSR_DATA_W'($urandom_range(17, 40));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 15) return 11'd1;
      return CSR_DATA_W'($urandom_range(2, 6));
   endfunction

   // Offers one input transaction and waits until the block takes it.
   task automatic offer(input logic fn, input logic [PIX_W-1:0] pix, input bit take_model);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.func <= fn;
      req_bus.pixel_in <= pix;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      filter_step(fn, pix);
      if (step_took) items_taken++;
      if (take_model) begin
         for (int i = 0; i < step_n; i++) due.push_back(step_out[i]);
      end
   endtask

   task automatic source_gap();
      int unsigned n;
      n = pick_gap(source_style);
      if (n > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Stops offering until every filtered pixel due has come out.
   task automatic wait_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due.size() != 0) @(negedge clock);
   endtask

   // The block is idle once nothing is due and its pipeline has emptied.
   task automatic quiesce();
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      apply_reg(idx, val);
   endtask

   // Sets up one frame geometry and streams whole frames through it, with
   // stray transactions mixed in and, when allowed, a frame cut short.
   task automatic run_frames(input logic [CSR_DATA_W-1:0] w_val,
                             input logic [CSR_DATA_W-1:0] h_val,
                             input int unsigned frames, input bit abort_ok,
                             input bit hold_sink, input bit force_pause);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned cut;
      quiesce();
      write_reg(CSR_FRAME_WIDTH, w_val);
      write_reg(CSR_FRAME_HEIGHT, h_val);
      write_reg(CSR_TRIM_MODE, CSR_DATA_W'($urandom_range(0, 7)));
      w = clamp_dim(w_val, MAX_WIDTH);
      h = clamp_dim(h_val, MAX_HEIGHT);
      total = w * h;
      source_style = $urandom_range(0, 2);
      if (hold_sink) sink_hold_asks++;
      for (int f = 0; f < frames; f++) begin
         cut = (abort_ok && $urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1)
                                                       : total;
         for (int unsigned p = 0; p < total; p++) begin
            if (p == cut) return;
            // A drain tick while the frame is still open must be ignored.
            if ($urandom_range(0, 39) == 0) begin
               offer(FUNC_DRAIN, pick_pixel(), 1'b1);
               source_gap();
            end
            if ((force_pause && p == total / 2) || $urandom_range(0, 149) == 0) begin
               wait_results();
            end
            offer(FUNC_PUSH, pick_pixel(), 1'b1);
            source_gap();
         end
         for (int unsigned p = 0; p < w; p++) begin
            // A pixel pushed while the last row drains must be ignored.
            if ($urandom_range(0, 19) == 0) begin
               offer(FUNC_PUSH, pick_pixel(), 1'b1);
               source_gap();
            end
            offer(FUNC_DRAIN, pick_pixel(), 1'b1);
            source_gap();
         end
      end
   endtask

   // Receiver side: random stalls in changing styles, plus long hold-offs on
   // request so that the result queue fills and the input backs up.
   initial begin : sink_side
      int unsigned n;
      int unsigned sink_style;
      int unsigned sink_left;
      rsp_bus.ready = 1'b0;
      sink_style = 0;
      sink_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_asks != sink_holds_done) begin
            sink_holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (sink_left == 0) begin
               sink_style = $urandom_range(0, 2);
               sink_left = $urandom_range(20, 200);
            end
            sink_left--;
            n = pick_gap(sink_style);
            if (n > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (n - 1) @(negedge clock);
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Each result transaction is checked against the oldest pixel due.
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing due", rsp_bus.pixel_out));
         end else begin
            want = due.pop_front();
            if (rsp_bus.pixel_out !== want.pixel_out) begin
               report_mismatch($sformatf("pixel_out %0d, want %0d",
                                         rsp_bus.pixel_out, want.pixel_out));
            end
            if (rsp_bus.row_end !== want.row_end) begin
               report_mismatch($sformatf("row_end %b, want %b",
                                         rsp_bus.row_end, want.row_end));
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               report_mismatch($sformatf("frame_end %b, want %b",
                                         rsp_bus.frame_end, want.frame_end));
            end
         end
      end
   end

   // Watchdog: the run ends if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_PUSH;
      req_bus.pixel_in = '0;
      for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
      win_q = '0;
      col_n = 0;
      row_n = 0;
      drain_n = 0;
      source_style = 1;

      // Directed part: one pixel frames with fixed results, stray transactions,
      // an out of range trim mode and register index, then a small 3x2 frame.
      plan = '{
         csr_row(CSR_FRAME_WIDTH, 11'd0),
         csr_row(CSR_FRAME_HEIGHT, 11'd0),
         fixed_row(FUNC_DRAIN, 8'h5A, 1'b0, 8'd0),
         fixed_row(FUNC_PUSH, 8'd0, 1'b0, 8'd0),
         fixed_row(FUNC_PUSH, 8'd255, 1'b0, 8'd0),
         fixed_row(FUNC_DRAIN, 8'hA5, 1'b1, 8'd0),
         fixed_row(FUNC_DRAIN, 8'd0, 1'b0, 8'd0),
         csr_row(CSR_TRIM_MODE, 11'd7),
         fixed_row(FUNC_PUSH, 8'd255, 1'b0, 8'd0),
         fixed_row(FUNC_DRAIN, 8'd255, 1'b1, 8'd255),
         csr_row(CSR_UNUSED, 11'd2047),
         csr_row(CSR_FRAME_WIDTH, 11'd3),
         csr_row(CSR_FRAME_HEIGHT, 11'd2),
         csr_row(CSR_TRIM_MODE, 11'd1),
         in_row(FUNC_PUSH, 8'd0),
         in_row(FUNC_PUSH, 8'd255),
         in_row(FUNC_PUSH, 8'd17),
         in_row(FUNC_PUSH, 8'd200),
         in_row(FUNC_PUSH, 8'd3),
         in_row(FUNC_PUSH, 8'd128),
         in_row(FUNC_DRAIN, 8'd0),
         in_row(FUNC_DRAIN, 8'd255),
         in_row(FUNC_DRAIN, 8'd64)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].is_csr) begin
            quiesce();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            offer(plan[i].fn, plan[i].pix, !plan[i].fixed);
            if (plan[i].fixed && plan[i].has_out) begin
               due.push_back('{pixel_out: plan[i].out_pix, row_end: 1'b1,
                               frame_end: 1'b1});
            end
            source_gap();
         end
      end

      // Random part: first a frame under a long receiver hold-off, then one
      // with a pause until everything is out, then random geometries.
      run_frames(11'd8, 11'd8, 1, 1'b0, 1'b1, 1'b0);
      run_frames(11'd6, 11'd4, 1, 1'b0, 1'b0, 1'b1);
      while (items_taken < RANDOM_ITEMS) begin
         run_frames(pick_width(), pick_height(), $urandom_range(1, 3), 1'b1, 1'b0, 1'b0);
      end

      // Width and height written above the limit saturate to the largest
      // frame, so a short start of its first row gives no result at all.
      quiesce();
      write_reg(CSR_FRAME_WIDTH, 11'd2047);
      write_reg(CSR_FRAME_HEIGHT, 11'd2047);
      for (int i = 0; i < WIDE_PUSHES; i++) begin
         offer(FUNC_PUSH, pick_pixel(), 1'b1);
         source_gap();
      end
      offer(FUNC_DRAIN, pick_pixel(), 1'b1);
      source_gap();

      quiesce();
      repeat (20) @(posedge clock);
      if (due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", due.size()));
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
